// ===== rtl/fat12_cluster_chain_walker_macros.svh =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH
`define FAT12_CLUSTER_CHAIN_WALKER_MACROS_SVH

// same-cycle implication
`define FCCW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/fccw_pkg.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker package
// Table geometry, codes, register defaults and controller/datapath types.
// ----------------------------------------------------------------------------
package fccw_pkg;

   // table geometry
   localparam int FAT_BYTES  = 8192;
   localparam int BANK_DEPTH = (FAT_BYTES + 1) / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int POS_W      = 17;
   localparam logic [POS_W-1:0] FAT_LAST_POS = POS_W'(FAT_BYTES - 1);
   localparam logic [POS_W-1:0] FAT_SIZE     = POS_W'(FAT_BYTES);

   // FAT12 entry constants
   localparam logic [11:0] END_MARK           = 12'hff7;
   localparam logic [11:0] ENTRY_MASK         = 12'hfff;
   localparam logic [11:0] FIRST_DATA_CLUSTER = 12'd2;

   // register defaults
   localparam logic [23:0] DATA_REGION_OFFSET_RST = 24'd16896;
   localparam logic [3:0]  CLUSTER_SHIFT_RST      = 4'd9;

   // stream packing
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_NEXT  = 2'd2
   } fccw_cmd_code_type;

   typedef enum logic [1:0] {
      ERR_OK          = 2'd0,
      ERR_NO_WALK     = 2'd1,
      ERR_BAD_CLUSTER = 2'd2
   } fccw_err_type;

   typedef enum logic {
      CSR_DATA_REGION_OFFSET = 1'b0,
      CSR_CLUSTER_SHIFT      = 1'b1
   } fccw_csr_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } fccw_state_type;

   typedef struct packed {
      logic load_en;
      logic start_en;
      logic read_en;
      logic emit_en;
   } fccw_cmd_type;

   typedef struct packed {
      logic rsp_full;
   } fccw_status_type;

endpackage

// ===== rtl/fat12_cluster_chain_walker.sv =====
// Load and start words: taken without leaving idle, so the block stays ready for the next word.
// Next word: table banks read at the accepting edge, result word registered once the
//   response register is free; no new request word is taken until then.
// A result word still waiting on rsp_tready holds the emit and keeps req_tready low.
// Reset: walk state and response cleared, registers back to their defaults;
//   the table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker
// Follows a FAT12 cluster chain through a loaded table and emits the image
// offset and copy length of each cluster.
// ----------------------------------------------------------------------------
module fat12_cluster_chain_walker (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // fat_address[12:0], fat_byte[20:13],
                                   // start_cluster[32:21], file_size[56:33]
   input  logic [1:0]  req_tuser,  // command[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // image_offset[27:0], byte_count[43:28]
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,  // error[1:0]
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import fccw_pkg::*;

   fccw_cmd_type    cmd;
   fccw_status_type status;

   fccw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   fccw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/fccw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fccw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/fccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker controller
// Takes request words, issues table loads, walk starts and table reads,
// and releases each result once the response register is free.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_macros.svh"

module fccw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_tuser,
   input  fccw_pkg::fccw_status_type status,
   output fccw_pkg::fccw_cmd_type    cmd
);
   import fccw_pkg::*;

   fccw_state_type    state_ff;
   fccw_state_type    state_in;
   fccw_cmd_code_type code;
   logic              accept;

   assign code       = fccw_cmd_code_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (code)
                  CMD_LOAD:  cmd.load_en  = 1'b1;
                  CMD_START: cmd.start_en = 1'b1;
                  CMD_NEXT: begin
                     cmd.read_en = 1'b1;
                     state_in    = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            // hold the result until the response register frees up
            if (!status.rsp_full) begin
               cmd.emit_en = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `FCCW_ASSERT_NEXT(a_next_goes_to_emit, clock, reset, accept && code == CMD_NEXT, state_ff == ST_EMIT, "next word did not start a table read")
   `FCCW_ASSERT_NEXT(a_emit_returns_idle, clock, reset, state_ff == ST_EMIT && !status.rsp_full, state_ff == ST_IDLE, "emit did not return to idle")
   `FCCW_ASSERT_NOW(a_one_action, clock, reset, 1'b1, $onehot0(cmd), "more than one datapath command at once")

endmodule

// ===== rtl/fccw_dp.sv =====
// ----------------------------------------------------------------------------
// FAT12 cluster chain walker datapath
// Banked table storage, walk state, configuration registers, result
// arithmetic and the response register.
// ----------------------------------------------------------------------------
`include "fat12_cluster_chain_walker_macros.svh"

module fccw_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  fccw_pkg::fccw_cmd_type    cmd,
   output fccw_pkg::fccw_status_type status,
   input  logic [fccw_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [23:0]              csr_wdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [fccw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                     rsp_tlast,
   output logic [1:0]               rsp_tuser
);
   import fccw_pkg::*;

   // request fields
   logic [12:0] fat_address;
   logic [7:0]  fat_byte;
   logic [11:0] start_cluster;
   logic [23:0] file_size;

   assign fat_address   = req_tdata[12:0];
   assign fat_byte      = req_tdata[20:13];
   assign start_cluster = req_tdata[32:21];
   assign file_size     = req_tdata[56:33];

   // configuration
   logic [23:0] region_ff;
   logic [3:0]  shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= DATA_REGION_OFFSET_RST;
         shift_ff  <= CLUSTER_SHIFT_RST;
      end else if (csr_we) begin
         unique case (fccw_csr_type'(csr_index))
            CSR_DATA_REGION_OFFSET: region_ff <= csr_wdata;
            CSR_CLUSTER_SHIFT:      shift_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // table banks: even bytes and odd bytes, so both bytes of an entry read at once
   logic [POS_W-1:0]   load_pos;
   logic [15:0]        load_half;
   logic               load_ok;
   logic               even_we;
   logic               odd_we;
   logic [POS_W-1:0]   pos;
   logic [15:0]        pos_half;
   logic [15:0]        pos_half_up;
   logic [BANK_AW-1:0] even_raddr;
   logic [BANK_AW-1:0] odd_raddr;
   logic [7:0]         even_rdata;
   logic [7:0]         odd_rdata;

   logic [11:0] cluster_ff;
   logic [11:0] cluster_in;
   logic [23:0] size_ff;
   logic [23:0] size_in;
   logic        active_ff;
   logic        active_in;

   assign load_pos  = POS_W'(fat_address);
   assign load_half = load_pos[16:1];
   assign load_ok   = load_pos < FAT_SIZE;
   assign even_we   = cmd.load_en && load_ok && !fat_address[0];
   assign odd_we    = cmd.load_en && load_ok && fat_address[0];

   assign pos         = POS_W'(cluster_ff) + POS_W'(cluster_ff[11:1]);
   assign pos_half    = pos[16:1];
   assign pos_half_up = pos_half + 16'd1;
   assign even_raddr  = pos[0] ? pos_half_up[BANK_AW-1:0] : pos_half[BANK_AW-1:0];
   assign odd_raddr   = pos_half[BANK_AW-1:0];

   fccw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_even_bank (
      .clock (clock),
      .we    (even_we),
      .waddr (load_half[BANK_AW-1:0]),
      .wdata (fat_byte),
      .re    (cmd.read_en),
      .raddr (even_raddr),
      .rdata (even_rdata)
   );

   fccw_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_odd_bank (
      .clock (clock),
      .we    (odd_we),
      .waddr (load_half[BANK_AW-1:0]),
      .wdata (fat_byte),
      .re    (cmd.read_en),
      .raddr (odd_raddr),
      .rdata (odd_rdata)
   );

   // entry decode and result arithmetic
   logic [15:0] entry_word;
   logic [11:0] entry;
   logic        bad;
   logic        end_of_chain;
   logic [15:0] full;
   logic [15:0] rem;
   logic [27:0] rel_off;
   logic [27:0] image_off;

   assign entry_word   = pos[0] ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
   assign entry        = cluster_ff[0] ? entry_word[15:4] : (entry_word[11:0] & ENTRY_MASK);
   assign bad          = (cluster_ff < FIRST_DATA_CLUSTER) || (pos >= FAT_LAST_POS);
   assign end_of_chain = entry >= END_MARK;
   assign full         = 16'd1 << shift_ff;
   assign rem          = size_ff[15:0] & (full - 16'd1);
   assign rel_off      = 28'(cluster_ff - FIRST_DATA_CLUSTER) << shift_ff;
   assign image_off    = rel_off + 28'(region_ff);

   // response register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [27:0]  off_ff;
   logic [27:0]  off_in;
   logic [15:0]  count_ff;
   logic [15:0]  count_in;
   logic         last_ff;
   logic         last_in;
   fccw_err_type err_ff;
   fccw_err_type err_in;

   always_comb begin
      cluster_in   = cluster_ff;
      size_in      = size_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      off_in       = off_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      err_in       = err_ff;

      if (cmd.start_en) begin
         cluster_in = start_cluster;
         size_in    = file_size;
         active_in  = start_cluster < END_MARK;
      end

      if (cmd.emit_en) begin
         rsp_valid_in = 1'b1;
         off_in       = '0;
         count_in     = '0;
         last_in      = 1'b0;
         priority if (!active_ff) begin
            err_in = ERR_NO_WALK;
         end else if (bad) begin
            err_in    = ERR_BAD_CLUSTER;
            active_in = 1'b0;
         end else begin
            err_in   = ERR_OK;
            off_in   = image_off;
            count_in = (end_of_chain && rem != 16'd0) ? rem : full;
            last_in  = end_of_chain;
            // drop the walk at the end marker, else advance along the chain
            if (end_of_chain) begin
               active_in = 1'b0;
            end else begin
               cluster_in = entry;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cluster_ff   <= '0;
         size_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cluster_ff   <= cluster_in;
         size_ff      <= size_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff   <= off_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   assign status.rsp_full = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {4'd0, count_ff, off_ff};
   assign rsp_tlast       = last_ff;
   assign rsp_tuser       = err_ff;

   `FCCW_ASSERT_NOW(a_emit_into_free_slot, clock, reset, cmd.emit_en, !(rsp_valid_ff && !rsp_tready), "result would overwrite a waiting word")
   `FCCW_ASSERT_NEXT(a_walk_ends, clock, reset, cmd.emit_en && active_ff && (bad || end_of_chain), !active_ff, "walk still active after its final cluster")
   `FCCW_ASSERT_NOW(a_error_word_empty, clock, reset, rsp_valid_ff && err_ff != ERR_OK, off_ff == 28'd0 && count_ff == 16'd0 && !last_ff, "error word carries data")

endmodule
